FILE: hdl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, state and select codes, and the command and status
// bundles between the interpolator's controller and datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int unsigned TABLE_DEPTH = 1024;
   localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int unsigned LEN_W       = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned CFG_W       = 11;
   localparam int unsigned CNT_W       = $clog2(DATA_W);

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_CHK_FIRST = 12'b0000_0000_0010,
      ST_CHK_LAST  = 12'b0000_0000_0100,
      ST_CACHE_LO  = 12'b0000_0000_1000,
      ST_CACHE_HI  = 12'b0000_0001_0000,
      ST_FWD       = 12'b0000_0010_0000,
      ST_BWD       = 12'b0000_0100_0000,
      ST_DIFF      = 12'b0000_1000_0000,
      ST_MUL       = 12'b0001_0000_0000,
      ST_DIV       = 12'b0010_0000_0000,
      ST_FIN       = 12'b0100_0000_0000,
      ST_OUT       = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [3:0] {
      ADDR_ZERO,
      ADDR_ONE,
      ADDR_LAST,
      ADDR_CACHE,
      ADDR_CACHE_P1,
      ADDR_CACHE_P2,
      ADDR_CACHE_M1,
      ADDR_PTR_P1,
      ADDR_PTR_M1
   } addr_sel_type;

   typedef enum logic [1:0] {
      RES_CLAMP,
      RES_FAULT,
      RES_INTERP
   } res_sel_type;

   typedef struct packed {
      logic         wr_en;
      logic         x_load;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         ptr_load;
      logic         lo_load;
      logic         hi_load;
      logic         hi_from_lo;
      logic         res_load;
      res_sel_type  res_sel;
      logic         cache_commit;
      logic         cache_drop;
      logic         diff_load;
      logic         mul_load;
      logic         div_step;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic x_le_rd;
      logic x_ge_rd;
      logic lo_le_x;
      logic x_le_hi;
      logic cache_ok;
      logic cache_p2_ok;
      logic cache_nonzero;
      logic ptr_next_ok;
      logic ptr_nonzero;
      logic div_done;
   } status_type;

endpackage

FILE: hdl/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for the interpolator: end checks, cached interval check,
// forward and backward interval walk, multiply and serial divide, result
// hand-off.
// ----------------------------------------------------------------------------
module pli_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  pli_pkg::status_type status,
   output pli_pkg::cmd_type    cmd
);

   pli_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.addr_sel = pli_pkg::ADDR_ZERO;
      cmd.res_sel  = pli_pkg::RES_FAULT;
      req_ready = 1'b0;

      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = pli_pkg::ADDR_ZERO;
            if (req_valid) begin
               if (req_func == pli_pkg::FUNC_WRITE) begin
                  cmd.wr_en      = 1'b1;
                  cmd.cache_drop = 1'b1;
               end else begin
                  cmd.x_load = 1'b1;
                  if (status.n_zero) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = pli_pkg::RES_FAULT;
                     state_in     = pli_pkg::ST_OUT;
                  end else begin
                     state_in = pli_pkg::ST_CHK_FIRST;
                  end
               end
            end
         end
         pli_pkg::ST_CHK_FIRST: begin
            if (status.x_le_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = pli_pkg::RES_CLAMP;
               state_in     = pli_pkg::ST_OUT;
            end else begin
               cmd.lo_load  = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = pli_pkg::ADDR_LAST;
               state_in     = pli_pkg::ST_CHK_LAST;
            end
         end
         pli_pkg::ST_CHK_LAST: begin
            if (status.x_ge_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = pli_pkg::RES_CLAMP;
               state_in     = pli_pkg::ST_OUT;
            end else if (status.cache_ok) begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = pli_pkg::ADDR_CACHE;
               state_in     = pli_pkg::ST_CACHE_LO;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = pli_pkg::ADDR_ONE;
               cmd.ptr_load = 1'b1;
               state_in     = pli_pkg::ST_FWD;
            end
         end
         pli_pkg::ST_CACHE_LO: begin
            cmd.lo_load  = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = pli_pkg::ADDR_CACHE_P1;
            state_in     = pli_pkg::ST_CACHE_HI;
         end
         pli_pkg::ST_CACHE_HI: begin
            if (status.lo_le_x && !status.x_ge_rd) begin
               cmd.hi_load = 1'b1;
               state_in    = pli_pkg::ST_DIFF;
            end else if (status.x_ge_rd) begin
               if (status.cache_p2_ok) begin
                  cmd.lo_load  = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.addr_sel = pli_pkg::ADDR_CACHE_P2;
                  cmd.ptr_load = 1'b1;
                  state_in     = pli_pkg::ST_FWD;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_sel    = pli_pkg::RES_FAULT;
                  cmd.cache_drop = 1'b1;
                  state_in       = pli_pkg::ST_OUT;
               end
            end else if (status.cache_nonzero) begin
               cmd.hi_from_lo = 1'b1;
               cmd.rd_en      = 1'b1;
               cmd.addr_sel   = pli_pkg::ADDR_CACHE_M1;
               cmd.ptr_load   = 1'b1;
               state_in       = pli_pkg::ST_BWD;
            end else begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = pli_pkg::RES_FAULT;
               cmd.cache_drop = 1'b1;
               state_in       = pli_pkg::ST_OUT;
            end
         end
         pli_pkg::ST_FWD: begin
            if (status.lo_le_x && status.x_le_rd) begin
               cmd.hi_load = 1'b1;
               state_in    = pli_pkg::ST_DIFF;
            end else if (status.ptr_next_ok) begin
               cmd.lo_load  = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = pli_pkg::ADDR_PTR_P1;
               cmd.ptr_load = 1'b1;
            end else begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = pli_pkg::RES_FAULT;
               cmd.cache_drop = 1'b1;
               state_in       = pli_pkg::ST_OUT;
            end
         end
         pli_pkg::ST_BWD: begin
            if (status.x_ge_rd && status.x_le_hi) begin
               cmd.lo_load = 1'b1;
               state_in    = pli_pkg::ST_DIFF;
            end else if (status.ptr_nonzero) begin
               cmd.hi_load  = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = pli_pkg::ADDR_PTR_M1;
               cmd.ptr_load = 1'b1;
            end else begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = pli_pkg::RES_FAULT;
               cmd.cache_drop = 1'b1;
               state_in       = pli_pkg::ST_OUT;
            end
         end
         pli_pkg::ST_DIFF: begin
            cmd.diff_load    = 1'b1;
            cmd.cache_commit = 1'b1;
            state_in         = pli_pkg::ST_MUL;
         end
         pli_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = pli_pkg::ST_DIV;
         end
         pli_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = pli_pkg::ST_FIN;
            end
         end
         pli_pkg::ST_FIN: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = pli_pkg::RES_INTERP;
            state_in     = pli_pkg::ST_OUT;
         end
         pli_pkg::ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pli_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/pli_dpath.sv
// ----------------------------------------------------------------------------
// pli_dpath
// Datapath of the interpolator: breakpoint RAM, length register, cached
// interval, interval bounds, multiplier, restoring divider and the result
// register.
// ----------------------------------------------------------------------------
module pli_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  pli_pkg::cmd_type                    cmd,
   output pli_pkg::status_type                 status,
   input  logic                                csr_wr_en,
   input  logic [pli_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic [pli_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [pli_pkg::DATA_W-1:0]          req_entry_x,
   input  logic signed [pli_pkg::DATA_W-1:0]   req_entry_value,
   input  logic [pli_pkg::DATA_W-1:0]          req_query_x,
   output logic signed [pli_pkg::DATA_W-1:0]   rsp_value,
   output logic                                rsp_clamped,
   output logic                                rsp_search_fault
);

   localparam int unsigned AW = pli_pkg::ADDR_W;
   localparam int unsigned LW = pli_pkg::LEN_W;
   localparam int unsigned DW = pli_pkg::DATA_W;

   logic [pli_pkg::CFG_W-1:0] table_len_ff;
   logic [AW-1:0]             last_ff;
   logic                      valid_ff;
   logic [LW-1:0]             n_eff;
   logic [AW-1:0]             ram_addr;
   logic [AW-1:0]             rd_addr_ff;
   logic [AW-1:0]             ptr_ff;
   logic [AW-1:0]             lo_idx_ff;
   logic                      wr_ok;
   logic [2*DW-1:0]           rd_data;
   logic [DW-1:0]             rd_x;
   logic [DW-1:0]             rd_v;
   logic [DW-1:0]             x_ff;
   logic [DW-1:0]             lo_x_ff, lo_v_ff, hi_x_ff, hi_v_ff;
   logic [DW:0]               df;
   logic [DW-1:0]             mag_ff, dx_ff, den_ff;
   logic                      neg_ff;
   logic [2*DW-1:0]           prod;
   logic [DW-1:0]             rem_ff, quot_ff;
   logic [pli_pkg::CNT_W-1:0] cnt_ff;
   logic [DW:0]               shifted;
   logic [DW:0]               sub;
   logic                      ge;
   logic [DW-1:0]             q;
   logic [DW-1:0]             interp;
   logic [DW-1:0]             res_v_ff;
   logic                      res_c_ff, res_f_ff;
   logic [DW-1:0]             out_v_ff;
   logic                      out_c_ff, out_f_ff;

   always_comb begin
      if (32'(table_len_ff) > 32'(pli_pkg::TABLE_DEPTH)) begin
         n_eff = LW'(pli_pkg::TABLE_DEPTH);
      end else begin
         n_eff = LW'(table_len_ff);
      end
   end

   always_comb begin
      unique case (cmd.addr_sel)
         pli_pkg::ADDR_ZERO:     ram_addr = '0;
         pli_pkg::ADDR_ONE:      ram_addr = AW'(1);
         pli_pkg::ADDR_LAST:     ram_addr = AW'(n_eff - LW'(1));
         pli_pkg::ADDR_CACHE:    ram_addr = last_ff;
         pli_pkg::ADDR_CACHE_P1: ram_addr = last_ff + AW'(1);
         pli_pkg::ADDR_CACHE_P2: ram_addr = last_ff + AW'(2);
         pli_pkg::ADDR_CACHE_M1: ram_addr = last_ff - AW'(1);
         pli_pkg::ADDR_PTR_P1:   ram_addr = ptr_ff + AW'(1);
         pli_pkg::ADDR_PTR_M1:   ram_addr = ptr_ff - AW'(1);
         default:                ram_addr = '0;
      endcase
   end

   assign wr_ok = cmd.wr_en && (32'(req_entry_index) < 32'(pli_pkg::TABLE_DEPTH));

   pli_ram #(
      .WIDTH (2 * DW),
      .DEPTH (pli_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_entry_x, req_entry_value}),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_addr),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[2*DW-1:DW];
   assign rd_v = rd_data[DW-1:0];

   // config and cached interval
   always_ff @(posedge clock) begin
      if (reset) begin
         table_len_ff <= '0;
         last_ff      <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            table_len_ff <= csr_wr_data;
         end
         if (csr_wr_en || cmd.cache_drop) begin
            valid_ff <= 1'b0;
         end else if (cmd.cache_commit) begin
            valid_ff <= 1'b1;
            last_ff  <= lo_idx_ff;
         end
      end
   end

   // interval bounds
   always_ff @(posedge clock) begin
      if (cmd.x_load) begin
         x_ff <= req_query_x;
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= ram_addr;
      end
      if (cmd.ptr_load) begin
         ptr_ff <= ram_addr;
      end
      if (cmd.lo_load) begin
         lo_x_ff   <= rd_x;
         lo_v_ff   <= rd_v;
         lo_idx_ff <= rd_addr_ff;
      end
      if (cmd.hi_from_lo) begin
         hi_x_ff <= lo_x_ff;
         hi_v_ff <= lo_v_ff;
      end else if (cmd.hi_load) begin
         hi_x_ff <= rd_x;
         hi_v_ff <= rd_v;
      end
   end

   assign status.n_zero        = (n_eff == '0);
   assign status.x_le_rd       = (x_ff <= rd_x);
   assign status.x_ge_rd       = (x_ff >= rd_x);
   assign status.lo_le_x       = (lo_x_ff <= x_ff);
   assign status.x_le_hi       = (x_ff <= hi_x_ff);
   assign status.cache_ok      = valid_ff && ((LW'(last_ff) + LW'(1)) < n_eff);
   assign status.cache_p2_ok   = (LW'(last_ff) + LW'(2)) < n_eff;
   assign status.cache_nonzero = (last_ff != '0);
   assign status.ptr_next_ok   = (LW'(ptr_ff) + LW'(1)) < n_eff;
   assign status.ptr_nonzero   = (ptr_ff != '0);
   assign status.div_done      = (cnt_ff == '1);

   // slope terms, product, restoring divide one bit per cycle
   assign df   = {hi_v_ff[DW-1], hi_v_ff} - {lo_v_ff[DW-1], lo_v_ff};
   assign prod = (2*DW)'(mag_ff) * (2*DW)'(dx_ff);

   assign shifted = {rem_ff, quot_ff[DW-1]};
   assign sub     = shifted - {1'b0, den_ff};
   assign ge      = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         neg_ff <= df[DW];
         mag_ff <= df[DW] ? DW'(-df) : df[DW-1:0];
         dx_ff  <= x_ff - lo_x_ff;
         den_ff <= hi_x_ff - lo_x_ff;
      end
      if (cmd.mul_load) begin
         rem_ff  <= prod[2*DW-1:DW];
         quot_ff <= prod[DW-1:0];
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? sub[DW-1:0] : shifted[DW-1:0];
         quot_ff <= {quot_ff[DW-2:0], ge};
         cnt_ff  <= cnt_ff + pli_pkg::CNT_W'(1);
      end
   end

   assign q      = (den_ff == '0) ? '0 : quot_ff;
   assign interp = neg_ff ? (lo_v_ff - q) : (lo_v_ff + q);

   // result and output registers
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         unique case (cmd.res_sel)
            pli_pkg::RES_CLAMP: begin
               res_v_ff <= rd_v;
               res_c_ff <= 1'b1;
               res_f_ff <= 1'b0;
            end
            pli_pkg::RES_INTERP: begin
               res_v_ff <= interp;
               res_c_ff <= 1'b0;
               res_f_ff <= 1'b0;
            end
            default: begin
               res_v_ff <= '0;
               res_c_ff <= 1'b0;
               res_f_ff <= 1'b1;
            end
         endcase
      end
      if (cmd.out_load) begin
         out_v_ff <= res_v_ff;
         out_c_ff <= res_c_ff;
         out_f_ff <= res_f_ff;
      end
   end

   assign rsp_value        = out_v_ff;
   assign rsp_clamped      = out_c_ff;
   assign rsp_search_fault = out_f_ff;

endmodule

FILE: hdl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with clamped piecewise linear interpolation.
// ----------------------------------------------------------------------------
// req channel (valid/ready) carries write beats (func 0: store entry_x and
// entry_value at entry_index) and query beats (func 1: interpolate at
// query_x). csr_wr_en/csr_wr_data set table_len; the user must see that it is
// written only while idle, as the block itself does not enforce this. Only
// queries produce an rsp beat: value, clamped, search_fault. A query on an
// empty table goes straight to the output state, one clamped at the first
// breakpoint after the first end check and one clamped at the last after
// the second. An interpolated answer runs through both end checks, the
// cached interval check when a cached interval is held, one walk step per
// interval examined when that check misses or nothing is cached, then
// slope, multiply, a 32-step restoring divide, the result register and the
// output register. A failed search goes from the checks or the walk
// straight to the output state. The walk reads one breakpoint per cycle
// from the single read port of the table RAM. One item is in work at a
// time; a new beat is taken once the previous result sits in the output
// register, even while rsp is stalled. A stalled rsp holds the next
// finished query until it drains. Reset clears table_len, the cached
// interval and rsp_valid; the table contents are undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [pli_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [pli_pkg::DATA_W-1:0]         req_entry_x,
   input  logic signed [pli_pkg::DATA_W-1:0]  req_entry_value,
   input  logic [pli_pkg::DATA_W-1:0]         req_query_x,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pli_pkg::DATA_W-1:0]  rsp_value,
   output logic                               rsp_clamped,
   output logic                               rsp_search_fault,
   input  logic                               csr_wr_en,
   input  logic [pli_pkg::CFG_W-1:0]          csr_wr_data
);

   pli_pkg::cmd_type    cmd;
   pli_pkg::status_type status;

   pli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pli_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_entry_index  (req_entry_index),
      .req_entry_x      (req_entry_x),
      .req_entry_value  (req_entry_value),
      .req_query_x      (req_query_x),
      .rsp_value        (rsp_value),
      .rsp_clamped      (rsp_clamped),
      .rsp_search_fault (rsp_search_fault)
   );

endmodule

FILE: sim/tb_piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Self-checking bench for the breakpoint table interpolator. A short table
// of directed beats covers the empty table, a single entry, both clamp
// ends, cache hits, forward and backward walks, a zero-width segment and
// extreme values. Random phases follow, each setting table_len, most filling
// the table, and then mixing queries and rewrites. Every rsp beat is checked
// field by field against a directed answer or an in-bench table/cache model.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;

   localparam int ITEM_TARGET = 2000;
   localparam int IDLE_PCT    = 36;
   localparam int SETTLE      = 8;
   localparam int TAIL        = 60;

   typedef struct packed {
      logic signed [pli_pkg::DATA_W-1:0] value;
      logic                              clamped;
      logic                              search_fault;
   } answer_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_WRITE, ROW_QUERY} row_kind_type;

   typedef struct {
      row_kind_type                row_kind;
      logic [pli_pkg::CFG_W-1:0]   len;
      logic [pli_pkg::INDEX_W-1:0] index;
      logic [pli_pkg::DATA_W-1:0]  x;
      logic [pli_pkg::DATA_W-1:0]  value;
      bit                          typed;
      answer_type                  want;
   } stim_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_func = pli_pkg::FUNC_WRITE;
   logic [pli_pkg::INDEX_W-1:0]       req_entry_index = '0;
   logic [pli_pkg::DATA_W-1:0]        req_entry_x = '0;
   logic signed [pli_pkg::DATA_W-1:0] req_entry_value = '0;
   logic [pli_pkg::DATA_W-1:0]        req_query_x = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [pli_pkg::DATA_W-1:0] rsp_value;
   logic                              rsp_clamped;
   logic                              rsp_search_fault;
   logic                              csr_wr_en = 1'b0;
   logic [pli_pkg::CFG_W-1:0]         csr_wr_data = '0;

   // model of the table, the cached segment and table_len
   logic [pli_pkg::DATA_W-1:0]        bp_x [pli_pkg::TABLE_DEPTH];
   logic signed [pli_pkg::DATA_W-1:0] bp_value [pli_pkg::TABLE_DEPTH];
   int unsigned                       seg_cached = 0;
   bit                                seg_cached_ok = 1'b0;
   int unsigned                       tbl_len_model = 0;

   answer_type   pending_answers[$];
   stim_row_type dir_rows[$];
   answer_type   rsp_want;
   int unsigned  req_beats = 0;
   int unsigned  fail_count = 0;
   bit           no_idle = 1'b0;

   piecewise_linear_interpolator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .req_entry_x      (req_entry_x),
      .req_entry_value  (req_entry_value),
      .req_query_x      (req_query_x),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_clamped      (rsp_clamped),
      .rsp_search_fault (rsp_search_fault),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic bit bracket(int unsigned i, logic [pli_pkg::DATA_W-1:0] x);
      return bp_x[i] <= x && x <= bp_x[i + 1];
   endfunction

   function automatic answer_type interpolate_at(logic [pli_pkg::DATA_W-1:0] x);
      answer_type                 ans;
      int unsigned                n, k, i, c;
      bit                         found, cache_usable;
      logic [pli_pkg::DATA_W-1:0] dxs, dens;
      longint                     f0, df, sum;
      logic [63:0]                mag, dx, den, q;
      ans = '0;
      found = 1'b0;
      k = 0;
      q = '0;
      n = (tbl_len_model > pli_pkg::TABLE_DEPTH) ? pli_pkg::TABLE_DEPTH : tbl_len_model;
      c = seg_cached;
      cache_usable = seg_cached_ok && (c + 1 < n);
      if (n == 0) begin
         ans.search_fault = 1'b1;
      end else if (x <= bp_x[0]) begin
         ans.value = bp_value[0];
         ans.clamped = 1'b1;
      end else if (x >= bp_x[n - 1]) begin
         ans.value = bp_value[n - 1];
         ans.clamped = 1'b1;
      end else begin
         if (cache_usable && bp_x[c] <= x && x < bp_x[c + 1]) begin
            k = c;
            found = 1'b1;
         end else if (!cache_usable) begin
            for (i = 0; i + 1 < n && !found; i++)
               if (bracket(i, x)) begin
                  k = i;
                  found = 1'b1;
               end
         end else if (x >= bp_x[c + 1]) begin
            for (i = c + 1; i + 1 < n && !found; i++)
               if (bracket(i, x)) begin
                  k = i;
                  found = 1'b1;
               end
         end else begin
            for (i = c; i > 0 && !found; i--)
               if (bracket(i - 1, x)) begin
                  k = i - 1;
                  found = 1'b1;
               end
         end
         if (!found) begin
            ans.search_fault = 1'b1;
            seg_cached_ok = 1'b0;
         end else begin
            f0 = longint'(bp_value[k]);
            df = longint'(bp_value[k + 1]) - f0;
            mag = (df < 0) ? -df : df;
            dxs = x - bp_x[k];
            dens = bp_x[k + 1] - bp_x[k];
            dx = {32'b0, dxs};
            den = {32'b0, dens};
            if (den != 0)
               q = (mag * dx) / den;
            sum = (df < 0) ? f0 - longint'(q) : f0 + longint'(q);
            ans.value = sum[pli_pkg::DATA_W-1:0];
            seg_cached = k;
            seg_cached_ok = 1'b1;
         end
      end
      return ans;
   endfunction

   function automatic logic [pli_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic log_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endtask

   task automatic put_row(row_kind_type kind, logic [pli_pkg::CFG_W-1:0] len,
                          logic [pli_pkg::INDEX_W-1:0] index,
                          logic [pli_pkg::DATA_W-1:0] x, logic [pli_pkg::DATA_W-1:0] value,
                          bit typed, answer_type want);
      stim_row_type r;
      r.row_kind = kind;
      r.len = len;
      r.index = index;
      r.x = x;
      r.value = value;
      r.typed = typed;
      r.want = want;
      dir_rows.insert(dir_rows.size(), r);
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic set_table_len(logic [pli_pkg::CFG_W-1:0] len);
      wait_for_answers();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tbl_len_model = len;
      seg_cached_ok = 1'b0;
   endtask

   task automatic send_item(logic func, logic [pli_pkg::INDEX_W-1:0] index,
                            logic [pli_pkg::DATA_W-1:0] x,
                            logic [pli_pkg::DATA_W-1:0] value, bit typed, answer_type want);
      answer_type got;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      if (func == pli_pkg::FUNC_WRITE) begin
         req_entry_index <= index;
         req_entry_x <= x;
         req_entry_value <= value;
         req_query_x <= $urandom;
      end else begin
         req_entry_index <= pli_pkg::INDEX_W'($urandom);
         req_entry_x <= $urandom;
         req_entry_value <= $urandom;
         req_query_x <= x;
      end
      do @(posedge clock); while (!req_ready);
      req_beats++;
      if (func == pli_pkg::FUNC_WRITE) begin
         bp_x[index] = x;
         bp_value[index] = value;
         seg_cached_ok = 1'b0;
      end else begin
         got = interpolate_at(x);
         pending_answers.insert(pending_answers.size(), typed ? want : got);
      end
   endtask

   always @(posedge clock) rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            log_failure($sformatf("unexpected rsp beat: value=%h clamped=%b fault=%b",
                                  rsp_value, rsp_clamped, rsp_search_fault));
         end else begin
            rsp_want = pending_answers.pop_front();
            if (rsp_value !== rsp_want.value || rsp_clamped !== rsp_want.clamped ||
                rsp_search_fault !== rsp_want.search_fault)
               log_failure($sformatf(
                  "rsp mismatch: exp value=%h clamped=%b fault=%b got value=%h clamped=%b fault=%b",
                  rsp_want.value, rsp_want.clamped, rsp_want.search_fault,
                  rsp_value, rsp_clamped, rsp_search_fault));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("** piecewise_linear_interpolator: FAILED **");
      $finish;
   end

   initial begin : stimulus
      stim_row_type                row;
      int                          phase, n_eff, body, r, sel, i;
      logic [pli_pkg::CFG_W-1:0]   len;
      logic [63:0]                 lo, hi, span, step, d, q64;
      logic [pli_pkg::DATA_W-1:0]  qx, prev_qx, a, b;
      logic [pli_pkg::INDEX_W-1:0] idx;
      bit                          up;

      // empty table, single entry, clamp ends
      put_row(ROW_WRITE, 0, 0, 32'h0001_0000, 32'h0002_0000, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'hFFFF_FFFF, 0, 1, {32'h0000_0000, 1'b0, 1'b1});
      put_row(ROW_CSR,   1, 0, 0, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h0000_0000, 0, 1, {32'h0002_0000, 1'b1, 1'b0});
      put_row(ROW_QUERY, 0, 0, 32'hFFFF_FFFF, 0, 1, {32'h0002_0000, 1'b1, 1'b0});
      // three points: fresh walk, cache hit, forward and backward walks
      put_row(ROW_WRITE, 0, 1, 32'h0003_0000, 32'hFFFE_0000, 0, '0);
      put_row(ROW_WRITE, 0, 2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, '0);
      put_row(ROW_CSR,   3, 0, 0, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h0001_0000, 0, 1, {32'h0002_0000, 1'b1, 1'b0});
      put_row(ROW_QUERY, 0, 0, 32'h0002_0000, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h0002_8000, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h8000_0000, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h0001_0001, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'hFFFF_FFFF, 0, 1, {32'h7FFF_FFFF, 1'b1, 1'b0});
      // zero-width segment in the middle, extreme slopes
      put_row(ROW_WRITE, 0, 0, 32'h0000_0000, 32'h8000_0000, 0, '0);
      put_row(ROW_WRITE, 0, 2, 32'h0003_0000, 32'h7FFF_FFFF, 0, '0);
      put_row(ROW_WRITE, 0, 3, 32'hFFFF_FFFF, 32'h8000_0000, 0, '0);
      put_row(ROW_CSR,   4, 0, 0, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h0001_0000, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h0003_0000, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'hFFFF_FFFE, 0, 0, '0);
      put_row(ROW_QUERY, 0, 0, 32'h0000_0001, 0, 0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < dir_rows.size(); i++) begin
         row = dir_rows[i];
         case (row.row_kind)
            ROW_CSR:   set_table_len(row.len);
            ROW_WRITE: send_item(pli_pkg::FUNC_WRITE, row.index, row.x, row.value, 1'b0, '0);
            default:   send_item(pli_pkg::FUNC_QUERY, '0, row.x, '0, row.typed, row.want);
         endcase
      end

      phase = 0;
      prev_qx = '0;
      up = 1'b1;
      while (req_beats < ITEM_TARGET) begin
         no_idle = (phase == 8 || phase == 9);
         if (phase == 5) begin
            len = 11'd1024;
         end else if (phase == 6) begin
            len = 11'd2047;
         end else begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
               len = '0;
            else if (sel == 1)
               len = 11'd1;
            else if (sel == 2)
               len = 11'd2;
            else if (sel == 9)
               len = pli_pkg::CFG_W'($urandom_range(17, 64));
            else
               len = pli_pkg::CFG_W'($urandom_range(3, 16));
         end
         set_table_len(len);
         n_eff = (len > pli_pkg::TABLE_DEPTH) ? pli_pkg::TABLE_DEPTH : int'(len);

         // fill: ascending spread, dense with repeats, full range, or unordered
         if (phase != 6) begin
            sel = $urandom_range(0, 9);
            lo = {32'b0, $urandom};
            hi = {32'b0, $urandom};
            if (lo > hi) begin
               span = lo;
               lo = hi;
               hi = span;
            end
            if (sel == 1)
               hi = lo + 64'($urandom_range(0, n_eff));
            if (sel == 2) begin
               lo = '0;
               hi = 64'hFFFF_FFFF;
            end
            span = hi - lo;
            for (i = 0; i < n_eff; i++) begin
               if (sel == 0)
                  a = $urandom;
               else if (n_eff > 1)
                  a = pli_pkg::DATA_W'(lo + span * 64'(i) / 64'(n_eff - 1));
               else
                  a = lo[pli_pkg::DATA_W-1:0];
               send_item(pli_pkg::FUNC_WRITE, pli_pkg::INDEX_W'(i), a, pick_value(), 1'b0, '0);
            end
         end

         body = (n_eff >= pli_pkg::TABLE_DEPTH) ? 12 : $urandom_range(20, 60);
         for (i = 0; i < body; i++) begin
            if ($urandom_range(99) < 3)
               wait_for_answers();
            r = $urandom_range(99);
            if (r < 15) begin
               if (n_eff > 0 && r < 9)
                  idx = pli_pkg::INDEX_W'($urandom_range(0, n_eff - 1));
               else
                  idx = pli_pkg::INDEX_W'($urandom);
               if (idx < n_eff && $urandom_range(0, 1) == 1)
                  a = bp_x[idx] + pli_pkg::DATA_W'($urandom_range(0, 255)) - 32'd128;
               else
                  a = $urandom;
               send_item(pli_pkg::FUNC_WRITE, idx, a, pick_value(), 1'b0, '0);
            end else begin
               if (n_eff == 0) begin
                  qx = $urandom;
               end else begin
                  a = bp_x[0];
                  b = bp_x[n_eff - 1];
                  lo = (a < b) ? {32'b0, a} : {32'b0, b};
                  hi = (a < b) ? {32'b0, b} : {32'b0, a};
                  span = hi - lo;
                  sel = $urandom_range(99);
                  if (sel < 50) begin
                     // ordered sweep near the previous query
                     if ($urandom_range(0, 7) == 0)
                        up = !up;
                     step = span / 64'(2 * n_eff) + 64'd1;
                     d = {32'b0, $urandom} % step;
                     q64 = up ? {32'b0, prev_qx} + d : {32'b0, prev_qx} - d;
                     if (q64 < lo || q64 > hi)
                        q64 = lo + ({32'b0, $urandom} % (span + 64'd1));
                     qx = q64[pli_pkg::DATA_W-1:0];
                  end else if (sel < 70) begin
                     q64 = lo + ({32'b0, $urandom} % (span + 64'd1));
                     qx = q64[pli_pkg::DATA_W-1:0];
                  end else if (sel < 85) begin
                     qx = bp_x[$urandom_range(0, n_eff - 1)]
                          + pli_pkg::DATA_W'($urandom_range(0, 2)) - 32'd1;
                  end else begin
                     qx = $urandom;
                  end
               end
               send_item(pli_pkg::FUNC_QUERY, '0, qx, '0, 1'b0, '0);
               prev_qx = qx;
            end
         end
         phase++;
      end

      no_idle = 1'b0;
      wait_for_answers();
      repeat (TAIL) @(posedge clock);
      if (pending_answers.size() != 0)
         log_failure($sformatf("%0d rsp beats never arrived", pending_answers.size()));
      if (fail_count == 0)
         $display("** piecewise_linear_interpolator: PASSED **");
      else
         $display("** piecewise_linear_interpolator: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/pli_ctrl.sv
hdl/pli_dpath.sv
hdl/piecewise_linear_interpolator.sv
sim/tb_piecewise_linear_interpolator.sv
